[rtl/core/qlt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_pkg
// Shared types, character codes and helpers for the quoted list tokenizer.
// ----------------------------------------------------------------------------
package qlt_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // register word index (paddr[2])
    localparam logic REG_IS_VECTOR = 1'b0;

    typedef enum logic [3:0] {
        ST_BETWEEN = 4'b0001,
        ST_BARE    = 4'b0010,
        ST_QUOTED  = 4'b0100,
        ST_AFTER   = 4'b1000
    } t_scan_state;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_QUOTE_BARE = 3'd1,
        ERR_TEXT_AFTER = 3'd2,
        ERR_UNCLOSED   = 3'd3,
        ERR_BAD_END    = 3'd4,
        ERR_SCALAR_CNT = 3'd5
    } t_err;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic [1:0] fields_closed;
        t_err       error_code;
        logic       record_done;
    } t_result;

    typedef struct packed {
        t_scan_state scan;
        logic        escape_pending;
        logic [1:0]  items_seen;
        logic        error_latched;
    } t_tok_state;

    localparam t_tok_state TOK_RESET = '{
        scan:           ST_BETWEEN,
        escape_pending: 1'b0,
        items_seen:     2'd0,
        error_latched:  1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

[rtl/core/qlt_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_cfg
// APB register slave holding the record type bit.
// ----------------------------------------------------------------------------
module qlt_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qlt_pkg::APB_AW-1:0]  paddr,
    input  logic [qlt_pkg::APB_DW-1:0]  pwdata,
    output logic [qlt_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic                        o_is_vector
);
    import qlt_pkg::*;

    logic r_is_vector;
    logic n_is_vector;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_IS_VECTOR);

    always_comb begin
        n_is_vector = r_is_vector;
        if (wr_hit) begin
            n_is_vector = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_vector <= 1'b0;
        end else begin
            r_is_vector <= n_is_vector;
        end
    end

    // read back; unmapped words read as zero
    always_comb begin
        prdata = '0;
        if (psel && (paddr[2] == REG_IS_VECTOR)) begin
            prdata = {{(APB_DW-1){1'b0}}, r_is_vector};
        end
    end

    assign o_is_vector = r_is_vector;

endmodule

[rtl/core/qlt_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_step
// Single-character tokenizer step: next state and result for one item.
// ----------------------------------------------------------------------------
module qlt_step (
    input  qlt_pkg::t_tok_state i_state,
    input  qlt_pkg::t_in_item   i_item,
    input  logic                i_is_vector,
    output qlt_pkg::t_tok_state o_state,
    output qlt_pkg::t_result    o_result
);
    import qlt_pkg::*;

    t_tok_state st;
    logic       app;
    logic [1:0] closed;
    t_err       err;
    logic       close_chr;
    logic       close_end;
    logic [7:0] c;

    assign c = i_item.ch;

    always_comb begin
        st        = i_state;
        app       = 1'b0;
        err       = ERR_NONE;
        close_chr = 1'b0;
        close_end = 1'b0;

        // character phase
        if (i_item.has_char && !i_state.error_latched) begin
            if (i_state.escape_pending) begin
                app               = 1'b1;
                st.escape_pending = 1'b0;
            end else begin
                case (i_state.scan)
                    ST_BETWEEN: begin
                        if (is_ws(c)) begin
                            st.scan = ST_BETWEEN;
                        end else if (c == CH_QUOTE) begin
                            st.scan = ST_QUOTED;
                        end else if (c == CH_BSLASH) begin
                            app               = 1'b1;
                            st.scan           = ST_BARE;
                            st.escape_pending = 1'b1;
                        end else if (c == CH_COMMA) begin
                            close_chr = 1'b1;
                        end else begin
                            app     = 1'b1;
                            st.scan = ST_BARE;
                        end
                    end
                    ST_BARE: begin
                        if (is_ws(c)) begin
                            st.scan = ST_AFTER;
                        end else if (c == CH_COMMA) begin
                            close_chr = 1'b1;
                            st.scan   = ST_BETWEEN;
                        end else if (c == CH_QUOTE) begin
                            err = ERR_QUOTE_BARE;
                        end else if (c == CH_BSLASH) begin
                            app               = 1'b1;
                            st.escape_pending = 1'b1;
                        end else begin
                            app = 1'b1;
                        end
                    end
                    ST_QUOTED: begin
                        if (c == CH_QUOTE) begin
                            st.scan = ST_AFTER;
                        end else if (c == CH_BSLASH) begin
                            app               = 1'b1;
                            st.escape_pending = 1'b1;
                        end else begin
                            app = 1'b1;
                        end
                    end
                    ST_AFTER: begin
                        if (is_ws(c)) begin
                            st.scan = ST_AFTER;
                        end else if (c == CH_COMMA) begin
                            close_chr = 1'b1;
                            st.scan   = ST_BETWEEN;
                        end else begin
                            err = ERR_TEXT_AFTER;
                        end
                    end
                    default: begin
                        st.scan = ST_BETWEEN;
                    end
                endcase
            end
            if (close_chr && (st.items_seen != 2'd3)) begin
                st.items_seen = st.items_seen + 2'd1;
            end
            if (err != ERR_NONE) begin
                st.error_latched = 1'b1;
            end
        end

        // end-of-list phase: close the last field and check the record
        if (i_item.last) begin
            if (!st.error_latched) begin
                if (st.scan == ST_QUOTED) begin
                    err = ERR_UNCLOSED;
                end else if (st.escape_pending) begin
                    err = ERR_BAD_END;
                end else if ((st.scan == ST_BARE) || (st.scan == ST_AFTER)) begin
                    close_end = 1'b1;
                end else if (i_is_vector) begin
                    close_end = (st.items_seen != 2'd0);
                end else begin
                    err = ERR_BAD_END;
                end
                if (close_end && (st.items_seen != 2'd3)) begin
                    st.items_seen = st.items_seen + 2'd1;
                end
                if ((err == ERR_NONE) && !i_is_vector && (st.items_seen != 2'd1)) begin
                    err = ERR_SCALAR_CNT;
                end
            end
            st = TOK_RESET;
        end
    end

    assign closed = {1'b0, close_chr} + {1'b0, close_end};

    assign o_state                 = st;
    assign o_result.char_out       = app ? c : 8'h00;
    assign o_result.char_valid     = app;
    assign o_result.fields_closed  = closed;
    assign o_result.error_code     = err;
    assign o_result.record_done    = i_item.last;

endmodule

[rtl/core/quoted_list_tokenizer_core.sv]
`timescale 1ns / 1ps
// Pipeline: an input transaction is held in the input register, its result
//   in the result register; one step of tokenizer logic sits between them.
// Throughput: 1 character per cycle unless the result channel stalls.
// Reset: synchronous, active low; clears both pipeline valids, the tokenizer
//   state (between items, no escape, zero count, no error) and is_vector.
// ----------------------------------------------------------------------------
// quoted_list_tokenizer_core
// Streams a comma-separated value list one byte per transaction and reports
// field characters, closed field counts, errors and end of record.
// ----------------------------------------------------------------------------
module quoted_list_tokenizer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_ch,
    input  logic                        i_has_char,
    input  logic                        i_last,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_char_out,
    output logic                        o_char_valid,
    output logic [1:0]                  o_fields_closed,
    output logic [2:0]                  o_error_code,
    output logic                        o_record_done,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qlt_pkg::APB_AW-1:0]  paddr,
    input  logic [qlt_pkg::APB_DW-1:0]  pwdata,
    output logic [qlt_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import qlt_pkg::*;

    logic       is_vector;

    // input register stage
    t_in_item   r_in;
    logic       r_in_valid;
    logic       n_in_valid;

    // tokenizer state, advanced once per item leaving the input register
    t_tok_state r_state;
    t_tok_state n_state;

    // result register stage
    t_result    r_out;
    t_result    step_result;
    logic       r_out_valid;
    logic       n_out_valid;

    logic       in_take;
    logic       out_free;
    logic       advance;

    qlt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_is_vector (is_vector)
    );

    qlt_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_is_vector (is_vector),
        .o_state     (n_state),
        .o_result    (step_result)
    );

    // The result register is free when empty or when its transaction
    // completes this cycle; the input register then moves its item forward.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= TOK_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // payload: capture on accepted transactions, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.ch       <= i_ch;
            r_in.has_char <= i_has_char;
            r_in.last     <= i_last;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_char_out      = r_out.char_out;
    assign o_char_valid    = r_out.char_valid;
    assign o_fields_closed = r_out.fields_closed;
    assign o_error_code    = r_out.error_code;
    assign o_record_done   = r_out.record_done;

endmodule
